@@ design/top_k_distinct_tracker_assert.svh @@
// assertion macros for the top-k distinct tracker
`ifndef TOP_K_DISTINCT_TRACKER_ASSERT_SVH
`define TOP_K_DISTINCT_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define TKDT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk_i, off during reset
`define TKDT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TKDT_ASSERT_IMP(label, ante, cons, msg)
`define TKDT_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ design/tkdt_pkg.sv @@
// shared constants and types of the top-k distinct tracker
`default_nettype none

package tkdt_pkg;

  localparam int MAX_KEEP = 16;
  localparam int VAL_W    = 32;
  localparam int KEEP_W   = 5;
  // count of held values, 0 .. MAX_KEEP
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  // count after an insert, 0 .. MAX_KEEP + 1
  localparam int GROW_W   = $clog2(MAX_KEEP + 2);
  localparam int CMP_W    = (GROW_W > KEEP_W) ? GROW_W : KEEP_W;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } tkdt_state_e;

  typedef struct packed {
    logic insert;
    logic finish;
    logic emit;
  } tkdt_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_one;
  } tkdt_stat_t;

endpackage

`default_nettype wire

@@ design/tkdt_ctrl.sv @@
// controller state machine of the top-k distinct tracker
`default_nettype none

module tkdt_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 cmd_i,
  input  wire tkdt_pkg::tkdt_stat_t stat_i,
  output tkdt_pkg::tkdt_cmd_t       cmd_o,
  output logic                      busy_o
);

  tkdt_pkg::tkdt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tkdt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.insert = 1'b0;
    cmd_o.finish = 1'b0;
    cmd_o.emit   = 1'b0;
    busy_o       = 1'b0;
    unique case (state_q)
      tkdt_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.insert = !cmd_i;
          cmd_o.finish = cmd_i;
          // an empty set answers at once and needs no emit pass
          if (cmd_i && !stat_i.count_zero) begin
            state_d = tkdt_pkg::ST_EMIT;
          end
        end
      end
      tkdt_pkg::ST_EMIT: begin
        busy_o     = 1'b1;
        cmd_o.emit = 1'b1;
        if (stat_i.last_one) begin
          state_d = tkdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tkdt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/tkdt_datapath.sv @@
// sorted register file, compare-and-shift insert and shift-out emit
`default_nettype none

module tkdt_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tkdt_pkg::tkdt_cmd_t               cmd_i,
  output tkdt_pkg::tkdt_stat_t                   stat_o,
  input  wire logic signed [tkdt_pkg::VAL_W-1:0] value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [tkdt_pkg::KEEP_W-1:0]       cfg_wdata_i,
  output logic                                   result_valid_o,
  output logic signed [tkdt_pkg::VAL_W-1:0]      out_value_o,
  output logic                                   is_last_o,
  output logic                                   set_empty_o
);

  localparam int M = tkdt_pkg::MAX_KEEP;

  // held values, ascending from entry 0; entries at or above count are stale
  logic signed [tkdt_pkg::VAL_W-1:0] vals_q [M];
  logic signed [tkdt_pkg::VAL_W-1:0] vals_d [M];
  logic signed [tkdt_pkg::VAL_W-1:0] work   [M+1];

  logic [tkdt_pkg::CNT_W-1:0]  count_q, count_d;
  logic [tkdt_pkg::CNT_W-1:0]  remain_q;
  logic [tkdt_pkg::KEEP_W-1:0] keep_q;

  logic                        res_valid_q;
  logic signed [tkdt_pkg::VAL_W-1:0] res_value_q;
  logic                        res_last_q;
  logic                        res_empty_q;

  logic [M-1:0]                held, lt, eq;
  logic                        present;
  logic                        drop;
  logic [tkdt_pkg::GROW_W-1:0] grow;
  logic [tkdt_pkg::CMP_W-1:0]  keep_ext, limit;

  always_comb begin
    for (int j = 0; j < M; j++) begin
      held[j] = tkdt_pkg::CNT_W'(j) < count_q;
      lt[j]   = held[j] && (vals_q[j] < value_i);
      eq[j]   = held[j] && (vals_q[j] == value_i);
    end
    present = |eq;

    // lt is a prefix of the held entries, so its edge marks the slot
    work[0] = (present || lt[0]) ? vals_q[0] : value_i;
    for (int j = 1; j < M; j++) begin
      if (present || lt[j]) begin
        work[j] = vals_q[j];
      end else if (lt[j-1]) begin
        work[j] = value_i;
      end else begin
        work[j] = vals_q[j-1];
      end
    end
    work[M] = lt[M-1] ? value_i : vals_q[M-1];

    grow     = tkdt_pkg::GROW_W'(count_q) + tkdt_pkg::GROW_W'(!present);
    keep_ext = tkdt_pkg::CMP_W'(keep_q);
    limit    = (keep_ext > tkdt_pkg::CMP_W'(M)) ? tkdt_pkg::CMP_W'(M) : keep_ext;
    drop     = tkdt_pkg::CMP_W'(grow) > limit;

    // drop the smallest when over the limit
    for (int j = 0; j < M; j++) begin
      vals_d[j] = drop ? work[j+1] : work[j];
    end
    count_d = drop ? tkdt_pkg::CNT_W'(grow - tkdt_pkg::GROW_W'(1))
                   : tkdt_pkg::CNT_W'(grow);
  end

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.last_one   = (remain_q == tkdt_pkg::CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      remain_q    <= '0;
      keep_q      <= tkdt_pkg::KEEP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.finish && (count_q == '0)) || cmd_i.emit;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      if (cmd_i.insert) begin
        count_q <= count_d;
      end
      if (cmd_i.finish) begin
        count_q  <= '0;
        remain_q <= count_q;
      end
      if (cmd_i.emit) begin
        remain_q <= remain_q - tkdt_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      vals_q <= vals_d;
    end
    if (cmd_i.finish) begin
      res_value_q <= '0;
      res_last_q  <= 1'b1;
      res_empty_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      res_value_q <= vals_q[0];
      res_last_q  <= (remain_q == tkdt_pkg::CNT_W'(1));
      res_empty_q <= 1'b0;
      // shift out smallest first
      for (int j = 0; j < M - 1; j++) begin
        vals_q[j] <= vals_q[j+1];
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_value_o    = res_value_q;
  assign is_last_o      = res_last_q;
  assign set_empty_o    = res_empty_q;

endmodule

`default_nettype wire

@@ design/top_k_distinct_tracker.sv @@
// Keeps the largest distinct signed values of a stream, up to keep_count of them
// (at most MAX_KEEP). A word is accepted when start_i is high and busy_o is low.
// An insert word (cmd_i = 0) leaves busy_o low, so inserts may come every cycle; the
// compare-and-shift runs across all entries of the sorted register file at once. A
// finish word (cmd_i = 1) with values held raises busy_o while the file shifts out
// one value per cycle, smallest first, and the next word can be taken once busy_o
// falls; with an empty set it gives one result marked set_empty_o the next cycle and
// busy_o never rises. Each result is shown on the result ports for one cycle under
// result_valid_o and cannot be held off. keep_count is written through cfg_we_i /
// cfg_wdata_i; the user does so only while the block is idle, which is not enforced.
`default_nettype none

`include "top_k_distinct_tracker_assert.svh"

module top_k_distinct_tracker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              cmd_i,
  input  wire logic signed [tkdt_pkg::VAL_W-1:0] value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [tkdt_pkg::KEEP_W-1:0]       cfg_wdata_i,
  output logic                                   result_valid_o,
  output logic signed [tkdt_pkg::VAL_W-1:0]      out_value_o,
  output logic                                   is_last_o,
  output logic                                   set_empty_o
);

  tkdt_pkg::tkdt_cmd_t  cmd;
  tkdt_pkg::tkdt_stat_t stat;

  tkdt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  tkdt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .out_value_o   (out_value_o),
    .is_last_o     (is_last_o),
    .set_empty_o   (set_empty_o)
  );

  `TKDT_ASSERT_NXT(a_empty_finish, cmd.finish && stat.count_zero, result_valid_o && set_empty_o && is_last_o, "empty finish must give one empty last word")
  `TKDT_ASSERT_NXT(a_emit_word, busy_o, result_valid_o && !set_empty_o, "each emit cycle must deliver a word")
  `TKDT_ASSERT_IMP(a_last_frees, result_valid_o && is_last_o, !busy_o, "busy after the last word")
  `TKDT_ASSERT_IMP(a_empty_is_last, result_valid_o && set_empty_o, is_last_o, "empty word not marked last")

endmodule

`default_nettype wire

@@ bench/tkdt_bench_pkg.sv @@
// command codes and result word type shared by the tracker bench files
`timescale 1ns / 100ps

package tkdt_bench_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic signed [tkdt_pkg::VAL_W-1:0] value;
    logic                              last;
    logic                              empty;
  } set_word_t;

endpackage

@@ bench/top_k_distinct_tracker_checker.sv @@
// checker that tracks the top-k set of the tracker and compares every emitted word
`timescale 1ns / 100ps

module top_k_distinct_tracker_checker
  import tkdt_pkg::*;
  import tkdt_bench_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_i,
  input  wire logic                     cmd_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [KEEP_W-1:0]        cfg_wdata_i,
  input  wire logic                     result_valid_i,
  input  wire logic signed [VAL_W-1:0]  out_value_i,
  input  wire logic                     is_last_i,
  input  wire logic                     set_empty_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            result_count_o
);

  // held values, ascending; one spare slot for the insert before the drop
  logic signed [VAL_W-1:0] top_vals [MAX_KEEP+1];
  int                      top_n;
  logic [KEEP_W-1:0]       keep_limit;
  set_word_t               set_words_due[$];
  int                      fails   = 0;
  int                      results = 0;

  task automatic fold_value(input logic signed [VAL_W-1:0] v);
    int  lim;
    int  pos;
    bit  seen;
    lim  = (keep_limit < MAX_KEEP) ? int'(keep_limit) : MAX_KEEP;
    pos  = 0;
    seen = 1'b0;
    for (int i = 0; i < top_n; i++) begin
      if (top_vals[i] == v) seen = 1'b1;
      if (top_vals[i] < v) pos = i + 1;
    end
    if (!seen) begin
      for (int i = top_n; i > pos; i--) top_vals[i] = top_vals[i-1];
      top_vals[pos] = v;
      top_n++;
    end
    // even a duplicate drops one value when the limit was lowered mid-set
    if (top_n > lim) begin
      for (int i = 1; i < top_n; i++) top_vals[i-1] = top_vals[i];
      top_n--;
    end
  endtask

  task automatic flush_top_set();
    set_word_t w;
    if (top_n == 0) begin
      w.value = '0;
      w.last  = 1'b1;
      w.empty = 1'b1;
      set_words_due.push_back(w);
    end else begin
      for (int i = 0; i < top_n; i++) begin
        w.value = top_vals[i];
        w.last  = (i == top_n - 1);
        w.empty = 1'b0;
        set_words_due.push_back(w);
      end
    end
    top_n = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    set_word_t want;
    if (!rst_ni) begin
      set_words_due.delete();
      top_n      = 0;
      keep_limit = KEEP_RESET;
    end else begin
      if (result_valid_i) begin
        results++;
        if (set_words_due.size() == 0) begin
          $error("unexpected result word: out_value %0d is_last %0b set_empty %0b",
                 out_value_i, is_last_i, set_empty_i);
          fails++;
        end else begin
          want = set_words_due.pop_front();
          if (out_value_i !== want.value) begin
            $error("out_value mismatch: expected %0d, got %0d", want.value, out_value_i);
            fails++;
          end
          if (is_last_i !== want.last) begin
            $error("is_last mismatch: expected %0b, got %0b", want.last, is_last_i);
            fails++;
          end
          if (set_empty_i !== want.empty) begin
            $error("set_empty mismatch: expected %0b, got %0b", want.empty, set_empty_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (cmd_i == CMD_FINISH) flush_top_set();
        else fold_value(value_i);
      end
      if (cfg_we_i) keep_limit = cfg_wdata_i;
    end
    fail_count_o   <= fails;
    pending_o      <= set_words_due.size();
    result_count_o <= results;
  end

endmodule

@@ bench/top_k_distinct_tracker_tb.sv @@
// stimulus and verdict for the top-k distinct tracker
`timescale 1ns / 100ps

module top_k_distinct_tracker_tb;
  import tkdt_pkg::*;
  import tkdt_bench_pkg::*;

  localparam int WORD_TARGET = 305;
  localparam int CYCLE_LIMIT = 200000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic                    cmd_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    cfg_we_i;
  logic [KEEP_W-1:0]       cfg_wdata_i;
  logic                    result_valid_o;
  logic signed [VAL_W-1:0] out_value_o;
  logic                    is_last_o;
  logic                    set_empty_o;

  int fail_count;
  int pending;
  int result_count;
  int cycles       = 0;
  int words_sent   = 0;
  int finishes     = 0;
  int limit_writes = 0;
  int burst_left   = 0;
  logic [KEEP_W-1:0] keep_now;

  top_k_distinct_tracker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .out_value_o    (out_value_o),
    .is_last_o      (is_last_o),
    .set_empty_o    (set_empty_o)
  );

  top_k_distinct_tracker_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_i (result_valid_o),
    .out_value_i    (out_value_o),
    .is_last_i      (is_last_o),
    .set_empty_i    (set_empty_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d result words still due", pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // one word per call; start stays high across a burst
  task automatic send_word(input logic c, input logic signed [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    burst_left--;
    words_sent++;
    if (c == CMD_FINISH) finishes++;
  endtask

  // pending is registered in the checker, so its value lags; keep waiting after it reads zero
  task automatic wait_idle();
    start_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] k);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    keep_now = k;
    limit_writes++;
  endtask

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd2;
      3: return 5'd15;
      4: return 5'd16;
      5: return 5'd17;
      6: return 5'd31;
      default: return KEEP_W'($urandom_range(0, 31));
    endcase
  endfunction

  // half of the picks fall in a narrow window above the set's base so duplicates are common
  function automatic logic signed [VAL_W-1:0] pick_value(input logic signed [VAL_W-1:0] base);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3, 4, 5: return base + VAL_W'($urandom_range(0, 11));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int                      set_len;
    int                      lower_at;
    logic signed [VAL_W-1:0] base;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    cmd_i       <= CMD_INSERT;
    value_i     <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    keep_now = KEEP_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty set, then the extremes with a duplicate
    send_word(CMD_FINISH, 32'sh7fff_ffff);
    send_word(CMD_INSERT, 32'sh8000_0000);
    send_word(CMD_INSERT, 32'sh7fff_ffff);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, -32'sd1);
    send_word(CMD_INSERT, 32'sh7fff_ffff);
    send_word(CMD_INSERT, 32'sd1);
    send_word(CMD_FINISH, 32'sd0);
    // keep nothing
    write_keep(5'd0);
    send_word(CMD_INSERT, 32'sd5);
    send_word(CMD_INSERT, -32'sd5);
    send_word(CMD_FINISH, 32'sd0);
    // keep two of five
    write_keep(5'd2);
    send_word(CMD_INSERT, 32'sd10);
    send_word(CMD_INSERT, -32'sd20);
    send_word(CMD_INSERT, 32'sd30);
    send_word(CMD_INSERT, 32'sh8000_0000);
    send_word(CMD_INSERT, 32'sd20);
    send_word(CMD_FINISH, 32'sd0);
    // saturated limit, then lowered mid-set so a duplicate still drops one
    write_keep(5'd31);
    send_word(CMD_INSERT, 32'sd1);
    send_word(CMD_INSERT, 32'sd2);
    send_word(CMD_INSERT, 32'sd3);
    send_word(CMD_INSERT, 32'sd4);
    write_keep(5'd1);
    send_word(CMD_INSERT, 32'sd3);
    send_word(CMD_INSERT, -32'sd7);
    send_word(CMD_FINISH, 32'sd0);

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 1) == 0) write_keep(pick_keep());
      base     = $urandom;
      set_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
      lower_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, set_len) : -1;
      for (int i = 0; i < set_len; i++) begin
        if (i == lower_at) write_keep(KEEP_W'($urandom_range(0, keep_now)));
        send_word(CMD_INSERT, pick_value(base));
      end
      send_word(CMD_FINISH, $urandom);
    end

    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    $display("sent %0d words in %0d sets across %0d keep_count writes",
             words_sent, finishes, limit_writes);
    $display("checked %0d result words against the predicted top sets", result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
